### hw/rtl/stc2d_pkg.sv
// ----------------------------------------------------------------------------
// stc2d_pkg: shared types and constants for the 2-D transform composer
// Node record layout, sine table builder, sequencer states and Q16.16 helpers.
// ----------------------------------------------------------------------------
package stc2d_pkg;

  localparam int NODE_COUNT = 256;
  localparam int NODE_BITS  = $clog2(NODE_COUNT);
  localparam int SINE_DEPTH = 1024;
  localparam int SINE_BITS  = $clog2(SINE_DEPTH);

  localparam logic [63:0] ONE_Q30    = 64'd1073741824;
  localparam logic [63:0] HALFPI_Q30 = 64'd1686629713;
  localparam logic [15:0] QUARTER    = 16'd16384;

  typedef logic signed [31:0] sine_tab_t [SINE_DEPTH];

  // world transform of one node, as held in the node memory
  typedef struct packed {
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
    logic signed [31:0] d;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic        [15:0] angle;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
  } node_rec_t;

  typedef enum logic [1:0] {ST_IDLE, ST_LOC, ST_MUL, ST_SUM} state_t;

  typedef struct packed {
    logic take;
    logic wr_en;
    logic out_load;
  } ctrl_t;

  // rounded Q16.16 product, before saturation
  function automatic logic signed [47:0] qmul(input logic signed [31:0] x,
                                              input logic signed [31:0] y);
    logic signed [63:0] p;
    p = 64'(x) * 64'(y) + 64'sd32768;
    return 48'(p >>> 16);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    if (v > 50'sd2147483647) return 32'sh7fffffff;
    if (v < -50'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // sine table, quadrant folding and Taylor series in Q2.30
  function automatic sine_tab_t build_sine();
    sine_tab_t tab;
    logic [63:0] q4, quad, rem, x, x2, t;
    logic signed [63:0] s, c, v;
    for (int k = 0; k < SINE_DEPTH; k++) begin
      q4   = 64'(k) * 64'd4;
      quad = (q4 / SINE_DEPTH) & 64'd3;
      rem  = q4 % SINE_DEPTH;
      x    = rem * HALFPI_Q30 / SINE_DEPTH;
      x2   = (x * x) >> 30;
      t    = x;
      s    = $signed(x);
      for (int n = 1; n <= 6; n++) begin
        t = ((t * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) s = s - $signed(t);
        else            s = s + $signed(t);
      end
      t = ONE_Q30;
      c = $signed(ONE_Q30);
      for (int n = 1; n <= 6; n++) begin
        t = ((t * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
        if (n % 2 == 1) c = c - $signed(t);
        else            c = c + $signed(t);
      end
      v = quad[0] ? c : s;
      if (v < 0) v = 0;
      v = (v + 64'sd8192) >>> 14;
      if (quad >= 64'd2) v = -v;
      tab[k] = v[31:0];
    end
    return tab;
  endfunction

endpackage

### hw/rtl/scene_transform_composer_2d_unit.sv
// ----------------------------------------------------------------------------
// scene_transform_composer_2d_unit: 2-D scene node transform composer
// Handles one item at a time: a four-step sequencer around the node memory
// (read parent, local products, world products, sum/write) finishes each
// item, waiting in sum/write while the output is stalled, before the next.
// Reset clears the sequencer and output valid; node memory is not cleared.
// ----------------------------------------------------------------------------
module scene_transform_composer_2d_unit
  import stc2d_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // node_id, parent_id, local_x, local_y, local_angle, scale_x, scale_y
  input  logic [159:0] s_tdata,
  // has_parent
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // out_node, world_x, world_y, world_angle_out, world_scale_x,
  // world_scale_y, lin_a, lin_b, lin_c, lin_d
  output logic [279:0] m_tdata
);

  localparam sine_tab_t SINE_TAB = build_sine();

  state_t state, state_next;
  ctrl_t  ctl;

  // captured item
  logic [7:0]         node;
  logic               child;
  logic signed [31:0] lx, ly, sx, sy;
  logic [15:0]        ang;

  logic signed [31:0] sn, cs;
  node_rec_t          mem [NODE_COUNT];
  node_rec_t          par;
  logic signed [31:0] la, lb, lc, ld;
  logic signed [47:0] p_aa, p_bc, p_ab, p_bd, p_ca, p_dc, p_cb, p_dd;
  logic signed [47:0] p_ax, p_by, p_cx, p_dy, p_sx, p_sy;
  node_rec_t          wrec;

  logic [NODE_BITS-1:0] pidx, nidx;
  logic [15:0]          in_ang, cos_ang;

  assign pidx    = NODE_BITS'(32'(s_tdata[15:8]) % NODE_COUNT);
  assign nidx    = NODE_BITS'(32'(node) % NODE_COUNT);
  assign in_ang  = s_tdata[95:80];
  assign cos_ang = in_ang + QUARTER;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (s_tvalid) state_next = ST_LOC;
      ST_LOC:  state_next = ST_MUL;
      ST_MUL:  state_next = ST_SUM;
      ST_SUM:  if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    unique case (state)
      ST_IDLE: ctl.take = !rst;
      ST_SUM:  begin
        ctl.wr_en    = !m_tvalid || m_tready;
        ctl.out_load = !m_tvalid || m_tready;
      end
      default: ctl = '0;
    endcase
  end

  assign s_tready = ctl.take;

  // input capture, sine/cosine ROM and parent read
  always_ff @(posedge clk) begin
    if (s_tvalid && ctl.take) begin
      node  <= s_tdata[7:0];
      lx    <= s_tdata[47:16];
      ly    <= s_tdata[79:48];
      ang   <= in_ang;
      sx    <= s_tdata[127:96];
      sy    <= s_tdata[159:128];
      child <= s_tuser;
      sn    <= SINE_TAB[in_ang[15 -: SINE_BITS]];
      cs    <= SINE_TAB[cos_ang[15 -: SINE_BITS]];
      par   <= mem[pidx];
    end
  end

  // local matrix
  always_ff @(posedge clk) begin
    if (state == ST_LOC) begin
      la <= sat32(50'(qmul(cs, sx)));
      lb <= sat32(-50'(qmul(sn, sy)));
      lc <= sat32(50'(qmul(sn, sx)));
      ld <= sat32(50'(qmul(cs, sy)));
    end
  end

  // parent by local products
  always_ff @(posedge clk) begin
    if (state == ST_MUL) begin
      p_aa <= qmul(par.a, la);
      p_bc <= qmul(par.b, lc);
      p_ab <= qmul(par.a, lb);
      p_bd <= qmul(par.b, ld);
      p_ca <= qmul(par.c, la);
      p_dc <= qmul(par.d, lc);
      p_cb <= qmul(par.c, lb);
      p_dd <= qmul(par.d, ld);
      p_ax <= qmul(par.a, lx);
      p_by <= qmul(par.b, ly);
      p_cx <= qmul(par.c, lx);
      p_dy <= qmul(par.d, ly);
      p_sx <= qmul(par.sx, sx);
      p_sy <= qmul(par.sy, sy);
    end
  end

  // sums and saturation for a child node; a root node takes its local transform
  always_comb begin
    if (child) begin
      wrec.a     = sat32(50'(p_aa) + 50'(p_bc));
      wrec.b     = sat32(50'(p_ab) + 50'(p_bd));
      wrec.c     = sat32(50'(p_ca) + 50'(p_dc));
      wrec.d     = sat32(50'(p_cb) + 50'(p_dd));
      wrec.tx    = sat32(50'(p_ax) + 50'(p_by) + 50'(par.tx));
      wrec.ty    = sat32(50'(p_cx) + 50'(p_dy) + 50'(par.ty));
      wrec.angle = par.angle + ang;
      wrec.sx    = sat32(50'(p_sx));
      wrec.sy    = sat32(50'(p_sy));
    end else begin
      wrec.a     = la;
      wrec.b     = lb;
      wrec.c     = lc;
      wrec.d     = ld;
      wrec.tx    = lx;
      wrec.ty    = ly;
      wrec.angle = ang;
      wrec.sx    = sx;
      wrec.sy    = sy;
    end
  end

  // node memory write-back
  always_ff @(posedge clk) begin
    if (ctl.wr_en) mem[nidx] <= wrec;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      m_tdata <= {wrec.d, wrec.c, wrec.b, wrec.a, wrec.sy, wrec.sx,
                  wrec.angle, wrec.ty, wrec.tx, node};
    end
  end

endmodule

### hw/rtl/stc2d_checker.sv
// ----------------------------------------------------------------------------
// stc2d_checker: port-level checks for the transform composer
// Watches the stream ports and is bound to the top level.
// ----------------------------------------------------------------------------
module stc2d_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [279:0] m_tdata
);

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // no result straight out of reset
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // one item in flight: no input beat right after another
  a_one: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while busy");

  // every accepted item is followed by a valid result beat
  a_lat: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |-> ##4 m_tvalid)
    else $error("result missing after accepted beat");

endmodule

bind scene_transform_composer_2d_unit stc2d_checker u_stc2d_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
